FILE: rtl/pcla_pkg.sv
// ----------------------------------------------------------------------------
// pcla_pkg
// Shared types and constants of the per-class label accuracy counter.
// ----------------------------------------------------------------------------
`default_nettype none

package pcla_pkg;

    localparam int COLOR_W    = 24;
    localparam int ACTION_W   = 2;
    localparam int INDEX_W    = 5;
    localparam int CNT_OUT_W  = 25;
    localparam int PERMILLE_W = 10;

    localparam logic [PERMILLE_W-1:0] PERMILLE_MAX = 10'd1000;

    localparam logic [ACTION_W-1:0] ACT_DISCOVER = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_COMPARE  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_REPORT   = 2'd2;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [COLOR_W-1:0]  label_color;
        logic [COLOR_W-1:0]  predicted_color;
    } t_in_item;

    typedef struct packed {
        logic [INDEX_W-1:0]    class_index;
        logic [COLOR_W-1:0]    class_color;
        logic [CNT_OUT_W-1:0]  correct_count;
        logic [CNT_OUT_W-1:0]  wrong_count;
        logic [CNT_OUT_W-1:0]  pixel_count;
        logic [PERMILLE_W-1:0] correct_permille;
        logic [PERMILLE_W-1:0] wrong_permille;
        logic [PERMILLE_W-1:0] share_permille;
        logic                  is_total;
        logic                  is_last;
    } t_out_item;

    typedef struct packed {
        logic cap;
        logic look;
        logic apply;
        logic rep_start;
        logic row_load;
        logic tot_load;
        logic out_load;
        logic row_next;
        logic rep_end;
    } t_cmd;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                div_done;
        logic                row_last;
        logic                tbl_empty;
    } t_sts;

endpackage

`default_nettype wire

FILE: rtl/pcla_div.sv
// ----------------------------------------------------------------------------
// pcla_div
// Bit-serial restoring divider for num*1000/den, clamped to 1000, 0 on den 0.
// ----------------------------------------------------------------------------
`default_nettype none

module pcla_div #(
    parameter int NW = 25
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic [NW-1:0]                     i_num,
    input  wire logic [NW-1:0]                     i_den,
    output logic                                   o_busy,
    output logic [pcla_pkg::PERMILLE_W-1:0]        o_quot
);

    localparam int DW = NW + 10;
    localparam int SW = $clog2(DW + 1);

    logic          r_busy;
    logic [SW-1:0] r_step;
    logic [DW-1:0] r_q;
    logic [NW:0]   r_r;
    logic [NW-1:0] r_den;
    logic          r_dz;

    logic [DW-1:0] scaled;
    logic [NW:0]   shifted;
    logic          ge;
    logic [NW:0]   n_r;

    always_comb begin
        scaled  = (DW'(i_num) << 10) - (DW'(i_num) << 4) - (DW'(i_num) << 3);
        shifted = {r_r[NW-1:0], r_q[DW-1]};
        ge      = shifted >= {1'b0, r_den};
        n_r     = ge ? (shifted - {1'b0, r_den}) : shifted;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= SW'(DW);
        end else if (r_busy) begin
            r_step <= r_step - SW'(1);
            if (r_step == SW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= scaled;
            r_r   <= '0;
            r_den <= i_den;
            r_dz  <= (i_den == '0);
        end else if (r_busy) begin
            r_q <= {r_q[DW-2:0], ge};
            r_r <= n_r;
        end
    end

    always_comb begin
        o_busy = r_busy;
        if (r_dz) begin
            o_quot = '0;
        end else if (r_q > DW'(pcla_pkg::PERMILLE_MAX)) begin
            o_quot = pcla_pkg::PERMILLE_MAX;
        end else begin
            o_quot = r_q[pcla_pkg::PERMILLE_W-1:0];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/pcla_dp.sv
// ----------------------------------------------------------------------------
// pcla_dp
// Datapath: class table, counters, row staging, dividers, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pcla_dp #(
    parameter int MAX_CLASSES = 32,
    parameter int COUNT_BITS  = 25
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire pcla_pkg::t_in_item   i_in_item,
    input  wire pcla_pkg::t_cmd       i_cmd,
    output pcla_pkg::t_sts            o_sts,
    output pcla_pkg::t_out_item       o_out_item
);

    localparam int IW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam int NW = $clog2(MAX_CLASSES + 1);
    localparam int CW = COUNT_BITS;
    localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

    logic [pcla_pkg::COLOR_W-1:0]  r_col [MAX_CLASSES];
    logic [CW-1:0]                 r_cor [MAX_CLASSES];
    logic [CW-1:0]                 r_wrg [MAX_CLASSES];
    logic [NW-1:0]                 r_cnt;
    logic [CW-1:0]                 r_pix;
    logic [pcla_pkg::ACTION_W-1:0] r_action;
    logic [pcla_pkg::COLOR_W-1:0]  r_lab;
    logic [pcla_pkg::COLOR_W-1:0]  r_pred;
    logic [MAX_CLASSES-1:0]        r_hit;
    logic [IW-1:0]                 r_row;
    logic [CW-1:0]                 r_csum;
    logic [CW-1:0]                 r_wsum;
    logic [CW-1:0]                 r_c;
    logic [CW-1:0]                 r_w;
    logic [CW-1:0]                 r_p;
    logic                          r_tot;
    pcla_pkg::t_out_item           r_out;

    logic [MAX_CLASSES-1:0] hit;
    logic [IW-1:0]          hit_idx;
    logic                   found;
    logic [CW-1:0]          rd_c;
    logic [CW-1:0]          rd_w;
    logic [CW:0]            sum_cw;
    logic [CW-1:0]          rd_p;
    logic [CW:0]            sum_c;
    logic [CW:0]            sum_w;
    logic [CW:0]            d0_num;
    logic [CW:0]            d0_den;
    logic [CW:0]            d1_num;
    logic [CW:0]            d1_den;
    logic [CW:0]            d2_num;
    logic [CW:0]            pix_ext;
    logic                   div_start;
    logic                   busy0;
    logic                   busy1;
    logic                   busy2;
    logic [pcla_pkg::PERMILLE_W-1:0] q0;
    logic [pcla_pkg::PERMILLE_W-1:0] q1;
    logic [pcla_pkg::PERMILLE_W-1:0] q2;

    always_comb begin
        for (int i = 0; i < MAX_CLASSES; i++) begin
            hit[i] = (NW'(i) < r_cnt) && (r_col[i] == r_lab);
        end
        hit_idx = '0;
        for (int i = 0; i < MAX_CLASSES; i++) begin
            hit_idx = hit_idx | (r_hit[i] ? IW'(i) : IW'(0));
        end
        found = |r_hit;

        rd_c    = r_cor[r_row];
        rd_w    = r_wrg[r_row];
        sum_cw  = {1'b0, rd_c} + {1'b0, rd_w};
        rd_p    = sum_cw[CW] ? CNT_MAX : sum_cw[CW-1:0];
        sum_c   = {1'b0, r_csum} + {1'b0, rd_c};
        sum_w   = {1'b0, r_wsum} + {1'b0, rd_w};
        pix_ext = {1'b0, r_pix};

        // row ratios use the unsaturated class sum; total ratios divide by the pixel count
        div_start = i_cmd.row_load | i_cmd.tot_load;
        if (i_cmd.tot_load) begin
            d0_num = {1'b0, r_csum};
            d1_num = {1'b0, r_wsum};
            d0_den = pix_ext;
            d1_den = pix_ext;
            d2_num = pix_ext;
        end else begin
            d0_num = {1'b0, rd_c};
            d1_num = {1'b0, rd_w};
            d0_den = sum_cw;
            d1_den = sum_cw;
            d2_num = sum_cw;
        end
    end

    pcla_div #(.NW(CW + 1)) u_div_c (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(d0_num), .i_den(d0_den), .o_busy(busy0), .o_quot(q0)
    );

    pcla_div #(.NW(CW + 1)) u_div_w (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(d1_num), .i_den(d1_den), .o_busy(busy1), .o_quot(q1)
    );

    pcla_div #(.NW(CW + 1)) u_div_s (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(d2_num), .i_den(pix_ext), .o_busy(busy2), .o_quot(q2)
    );

    // control-side state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_pix <= '0;
            for (int i = 0; i < MAX_CLASSES; i++) begin
                r_cor[i] <= '0;
                r_wrg[i] <= '0;
            end
        end else begin
            if (i_cmd.apply) begin
                if (r_action == pcla_pkg::ACT_DISCOVER) begin
                    if (!found && (r_cnt < NW'(MAX_CLASSES))) begin
                        r_cnt <= r_cnt + NW'(1);
                    end
                end else if (r_action == pcla_pkg::ACT_COMPARE) begin
                    if (found) begin
                        if (r_lab == r_pred) begin
                            if (r_cor[hit_idx] != CNT_MAX) begin
                                r_cor[hit_idx] <= r_cor[hit_idx] + CW'(1);
                            end
                        end else begin
                            if (r_wrg[hit_idx] != CNT_MAX) begin
                                r_wrg[hit_idx] <= r_wrg[hit_idx] + CW'(1);
                            end
                        end
                    end
                    if (r_pix != CNT_MAX) begin
                        r_pix <= r_pix + CW'(1);
                    end
                end
            end
            if (i_cmd.row_load) begin
                r_cor[r_row] <= '0;
                r_wrg[r_row] <= '0;
            end
            if (i_cmd.rep_end) begin
                r_pix <= '0;
            end
        end
    end

    // payload state
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_action <= i_in_item.action;
            r_lab    <= i_in_item.label_color;
            r_pred   <= i_in_item.predicted_color;
        end
        if (i_cmd.look) begin
            r_hit <= hit;
        end
        if (i_cmd.apply && (r_action == pcla_pkg::ACT_DISCOVER) && !found
                && (r_cnt < NW'(MAX_CLASSES))) begin
            r_col[r_cnt[IW-1:0]] <= r_lab;
        end
        if (i_cmd.rep_start) begin
            r_row  <= '0;
            r_csum <= '0;
            r_wsum <= '0;
        end
        if (i_cmd.row_load) begin
            r_c    <= rd_c;
            r_w    <= rd_w;
            r_p    <= rd_p;
            r_tot  <= 1'b0;
            r_csum <= sum_c[CW] ? CNT_MAX : sum_c[CW-1:0];
            r_wsum <= sum_w[CW] ? CNT_MAX : sum_w[CW-1:0];
        end
        if (i_cmd.tot_load) begin
            r_c   <= r_csum;
            r_w   <= r_wsum;
            r_p   <= r_pix;
            r_tot <= 1'b1;
        end
        if (i_cmd.row_next) begin
            r_row <= r_row + IW'(1);
        end
        if (i_cmd.out_load) begin
            r_out.class_index      <= r_tot ? '0 : pcla_pkg::INDEX_W'(r_row);
            r_out.class_color      <= r_tot ? '0 : r_col[r_row];
            r_out.correct_count    <= pcla_pkg::CNT_OUT_W'(r_c);
            r_out.wrong_count      <= pcla_pkg::CNT_OUT_W'(r_w);
            r_out.pixel_count      <= pcla_pkg::CNT_OUT_W'(r_p);
            r_out.correct_permille <= q0;
            r_out.wrong_permille   <= q1;
            r_out.share_permille   <= q2;
            r_out.is_total         <= r_tot;
            r_out.is_last          <= r_tot;
        end
    end

    always_comb begin
        o_sts.action    = r_action;
        o_sts.div_done  = !(busy0 | busy1 | busy2);
        o_sts.row_last  = (NW'(r_row) == (r_cnt - NW'(1)));
        o_sts.tbl_empty = (r_cnt == '0);
        o_out_item      = r_out;
    end

endmodule

`default_nettype wire

FILE: rtl/pcla_ctrl.sv
// ----------------------------------------------------------------------------
// pcla_ctrl
// Controller: sequences lookup, update and the report rows.
// ----------------------------------------------------------------------------
`default_nettype none

module pcla_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    input  wire pcla_pkg::t_sts i_sts,
    output pcla_pkg::t_cmd      o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_LOOK    = 9'b000000010,
        S_APPLY   = 9'b000000100,
        S_ROW_LD  = 9'b000001000,
        S_ROW_DIV = 9'b000010000,
        S_ROW_OUT = 9'b000100000,
        S_TOT_LD  = 9'b001000000,
        S_TOT_DIV = 9'b010000000,
        S_TOT_OUT = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_LOOK;
                end
            end
            S_LOOK: begin
                o_cmd.look = 1'b1;
                if (i_sts.action == pcla_pkg::ACT_REPORT) begin
                    o_cmd.rep_start = 1'b1;
                    n_state = i_sts.tbl_empty ? S_TOT_LD : S_ROW_LD;
                end else if (i_sts.action == pcla_pkg::ACT_DISCOVER
                        || i_sts.action == pcla_pkg::ACT_COMPARE) begin
                    n_state = S_APPLY;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state     = S_IDLE;
            end
            S_ROW_LD: begin
                o_cmd.row_load = 1'b1;
                n_state        = S_ROW_DIV;
            end
            S_ROW_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_ROW_OUT;
                end
            end
            S_ROW_OUT: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) begin
                    if (i_sts.row_last) begin
                        n_state = S_TOT_LD;
                    end else begin
                        o_cmd.row_next = 1'b1;
                        n_state        = S_ROW_LD;
                    end
                end
            end
            S_TOT_LD: begin
                o_cmd.tot_load = 1'b1;
                n_state        = S_TOT_DIV;
            end
            S_TOT_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_TOT_OUT;
                end
            end
            S_TOT_OUT: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) begin
                    o_cmd.rep_end = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/per_class_label_accuracy_counter_top.sv
// ----------------------------------------------------------------------------
// per_class_label_accuracy_counter_top
// Segmentation scoring: class discovery, per-class pixel counting, reports.
//
//   channel  | valid       | stall       | payload
//   input    | i_in_valid  | o_in_stall  | i_in_item  (t_in_item)
//   output   | o_out_valid | i_out_stall | o_out_item (t_out_item)
//
// discover and compare items go through capture, registered table match and
// update. a report row is loaded, divided by the bit-serial permille dividers
// and held until the output takes it; the total row follows.
// one item at a time; o_in_stall is high until the item is finished.
// synchronous active-low reset clears the table fill count and all counters.
// ----------------------------------------------------------------------------
`default_nettype none

module per_class_label_accuracy_counter_top #(
    parameter int MAX_CLASSES = 32,
    parameter int COUNT_BITS  = 25
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire pcla_pkg::t_in_item  i_in_item,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output pcla_pkg::t_out_item      o_out_item
);

    pcla_pkg::t_cmd cmd;
    pcla_pkg::t_sts sts;

    pcla_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    pcla_dp #(
        .MAX_CLASSES (MAX_CLASSES),
        .COUNT_BITS  (COUNT_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_item  (i_in_item),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out_item (o_out_item)
    );

`ifndef ASSERT_OFF
    a_no_out_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> !o_out_valid)
        else $error("output valid while accepting input");

    a_last_is_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.is_last == o_out_item.is_total))
        else $error("last flag differs from total flag");

    a_total_row_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.is_total) |->
            (o_out_item.class_index == '0 && o_out_item.class_color == '0))
        else $error("total row carries class fields");
`endif

endmodule

`default_nettype wire
